>>> hdl/rdtc_pkg.sv
// Shared types and constants of the retry/deadline transfer controller.
`default_nettype none

package rdtc_pkg;

    // Raw event codes on the input port
    localparam logic [2:0] OPC_BEGIN   = 3'd0;
    localparam logic [2:0] OPC_RESULT  = 3'd1;
    localparam logic [2:0] OPC_TICK    = 3'd2;
    localparam logic [2:0] OPC_CANCEL  = 3'd3;
    localparam logic [2:0] OPC_RELEASE = 3'd4;

    // Raw attempt outcome codes; anything else counts as retryable
    localparam logic [1:0] OUTC_SUCCESS   = 2'd0;
    localparam logic [1:0] OUTC_PERMANENT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRY_LIMIT       = 2'd0;
    localparam logic [1:0] CFG_TOTAL_DEADLINE  = 2'd1;
    localparam logic [1:0] CFG_ATTEMPT_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_BACKOFF_TIME    = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  RST_TRY_LIMIT       = 8'd3;
    localparam logic [31:0] RST_TOTAL_DEADLINE  = 32'd60000;
    localparam logic [31:0] RST_ATTEMPT_TIMEOUT = 32'd10000;
    localparam logic [31:0] RST_BACKOFF_TIME    = 32'd1000;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SENDING   = 3'd1,
        PH_BACKOFF   = 3'd2,
        PH_SUCCEEDED = 3'd3,
        PH_FAILED    = 3'd4,
        PH_CANCELLED = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        FK_NONE      = 3'd0,
        FK_EXHAUSTED = 3'd1,
        FK_PERMANENT = 3'd2,
        FK_CANCELLED = 3'd3,
        FK_DEADLINE  = 3'd4
    } t_fail;

    // Decoded event class
    typedef enum logic [2:0] {
        EV_BEGIN,
        EV_RESULT,
        EV_TICK,
        EV_CANCEL,
        EV_RELEASE,
        EV_NOP
    } t_event;

    typedef enum logic [1:0] {
        OC_SUCCESS,
        OC_RETRY,
        OC_PERMANENT
    } t_outcome;

    typedef struct packed {
        logic [7:0]  try_limit;
        logic [31:0] total_deadline;
        logic [31:0] attempt_timeout;
        logic [31:0] backoff_time;
    } t_cfg;

    // Classified event handed from front to back
    typedef struct packed {
        t_event      ev;
        t_outcome    oc;
        logic [63:0] now;
        logic [31:0] tag;
        logic [63:0] deadline_sum;   // now + total_deadline
        logic [63:0] backoff_sum;    // now + backoff_time
    } t_cmd;

    typedef struct packed {
        logic        accepted;
        t_phase      phase;
        t_fail       failure;
        logic [7:0]  attempts;
        logic        send;
        logic [31:0] send_tag;
        logic        abort;
        logic        fin;
        logic        fin_ok;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/rdtc_fifo.sv
// Small register FIFO used for the command queue and the result queue.
`default_nettype none

module rdtc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (wr_en) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rdtc_front.sv
// Front end: decodes the raw event and precomputes the time sums it may need.
`default_nettype none

module rdtc_front (
    input  wire logic [2:0]   i_op,
    input  wire logic [1:0]   i_outcome,
    input  wire logic [63:0]  i_now_time,
    input  wire logic [31:0]  i_transfer_tag,
    input  wire logic [31:0]  i_total_deadline,
    input  wire logic [31:0]  i_backoff_time,
    output rdtc_pkg::t_cmd    o_cmd
);

    always_comb begin
        o_cmd.now = i_now_time;
        o_cmd.tag = i_transfer_tag;
        // sums wrap mod 2^64
        o_cmd.deadline_sum = i_now_time + {32'd0, i_total_deadline};
        o_cmd.backoff_sum  = i_now_time + {32'd0, i_backoff_time};

        unique case (i_op)
            rdtc_pkg::OPC_BEGIN:   o_cmd.ev = rdtc_pkg::EV_BEGIN;
            rdtc_pkg::OPC_RESULT:  o_cmd.ev = rdtc_pkg::EV_RESULT;
            rdtc_pkg::OPC_TICK:    o_cmd.ev = rdtc_pkg::EV_TICK;
            rdtc_pkg::OPC_CANCEL:  o_cmd.ev = rdtc_pkg::EV_CANCEL;
            rdtc_pkg::OPC_RELEASE: o_cmd.ev = rdtc_pkg::EV_RELEASE;
            default:               o_cmd.ev = rdtc_pkg::EV_NOP;
        endcase

        unique case (i_outcome)
            rdtc_pkg::OUTC_SUCCESS:   o_cmd.oc = rdtc_pkg::OC_SUCCESS;
            rdtc_pkg::OUTC_PERMANENT: o_cmd.oc = rdtc_pkg::OC_PERMANENT;
            default:                  o_cmd.oc = rdtc_pkg::OC_RETRY;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/rdtc_back.sv
// Back end: transfer state machine, one classified event per cycle while the result queue has room.
`default_nettype none

module rdtc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [7:0]      i_try_limit,
    input  wire logic [31:0]     i_attempt_timeout,
    input  wire rdtc_pkg::t_cmd  i_cmd,
    input  wire logic            i_cmd_valid,
    output logic                 o_cmd_pop,
    input  wire logic            i_res_full,
    output rdtc_pkg::t_result    o_res,
    output logic                 o_res_push
);

    rdtc_pkg::t_phase r_phase, n_phase;
    rdtc_pkg::t_fail  r_fail, n_fail;
    logic [7:0]       r_attempts, n_attempts;
    logic [63:0]      r_attempt_start, n_attempt_start;
    logic [63:0]      r_deadline_at, n_deadline_at;
    logic [63:0]      r_backoff_until, n_backoff_until;
    logic [31:0]      r_tag, n_tag;

    logic go;
    logic sending, busy;
    logic dl_hit, to_hit, bo_hit, exhausted;
    logic begin_ok, begin_zero, res_act, tick_dl, tick_restart, cancel_ok, release_ok;
    logic [63:0] elapsed;
    rdtc_pkg::t_outcome res_oc;

    assign go        = i_cmd_valid && !i_res_full;
    assign o_cmd_pop = go;

    assign sending   = (r_phase == rdtc_pkg::PH_SENDING);
    assign busy      = sending || (r_phase == rdtc_pkg::PH_BACKOFF);
    assign elapsed   = i_cmd.now - r_attempt_start;
    assign dl_hit    = (i_cmd.now >= r_deadline_at);
    assign to_hit    = (elapsed >= {32'd0, i_attempt_timeout});
    assign bo_hit    = (i_cmd.now >= r_backoff_until);
    assign exhausted = (r_attempts >= i_try_limit);

    assign begin_ok     = (i_cmd.ev == rdtc_pkg::EV_BEGIN) && !busy;
    assign begin_zero   = begin_ok && (i_try_limit == 8'd0);
    assign tick_dl      = (i_cmd.ev == rdtc_pkg::EV_TICK) && busy && dl_hit;
    // attempt timeout is handled as a retryable result
    assign res_act      = sending && ((i_cmd.ev == rdtc_pkg::EV_RESULT) ||
                          ((i_cmd.ev == rdtc_pkg::EV_TICK) && !dl_hit && to_hit));
    assign res_oc       = (i_cmd.ev == rdtc_pkg::EV_RESULT) ? i_cmd.oc : rdtc_pkg::OC_RETRY;
    assign tick_restart = (i_cmd.ev == rdtc_pkg::EV_TICK) &&
                          (r_phase == rdtc_pkg::PH_BACKOFF) && !dl_hit && bo_hit;
    assign cancel_ok    = (i_cmd.ev == rdtc_pkg::EV_CANCEL) && busy;
    assign release_ok   = (i_cmd.ev == rdtc_pkg::EV_RELEASE) && !busy;

    // next state
    always_comb begin
        n_phase         = r_phase;
        n_fail          = r_fail;
        n_attempts      = r_attempts;
        n_attempt_start = r_attempt_start;
        n_deadline_at   = r_deadline_at;
        n_backoff_until = r_backoff_until;
        n_tag           = r_tag;
        priority if (begin_ok) begin
            n_tag           = i_cmd.tag;
            n_fail          = rdtc_pkg::FK_NONE;
            n_backoff_until = '0;
            n_deadline_at   = i_cmd.deadline_sum;
            if (begin_zero) begin
                n_attempts = 8'd0;
                n_phase    = rdtc_pkg::PH_FAILED;
                n_fail     = rdtc_pkg::FK_EXHAUSTED;
            end else begin
                n_attempts      = 8'd1;
                n_attempt_start = i_cmd.now;
                n_phase         = rdtc_pkg::PH_SENDING;
            end
        end else if (tick_dl || (res_act && res_oc == rdtc_pkg::OC_RETRY &&
                                 !exhausted && dl_hit)) begin
            n_phase = rdtc_pkg::PH_FAILED;
            n_fail  = rdtc_pkg::FK_DEADLINE;
        end else if (res_act) begin
            unique case (res_oc)
                rdtc_pkg::OC_SUCCESS: begin
                    n_phase = rdtc_pkg::PH_SUCCEEDED;
                    n_fail  = rdtc_pkg::FK_NONE;
                end
                rdtc_pkg::OC_PERMANENT: begin
                    n_phase = rdtc_pkg::PH_FAILED;
                    n_fail  = rdtc_pkg::FK_PERMANENT;
                end
                default: begin
                    if (exhausted) begin
                        n_phase = rdtc_pkg::PH_FAILED;
                        n_fail  = rdtc_pkg::FK_EXHAUSTED;
                    end else begin
                        n_phase         = rdtc_pkg::PH_BACKOFF;
                        n_backoff_until = i_cmd.backoff_sum;
                    end
                end
            endcase
        end else if (tick_restart) begin
            n_attempts      = r_attempts + 8'd1;
            n_attempt_start = i_cmd.now;
            n_phase         = rdtc_pkg::PH_SENDING;
        end else if (cancel_ok) begin
            n_phase = rdtc_pkg::PH_CANCELLED;
            n_fail  = rdtc_pkg::FK_CANCELLED;
        end else if (release_ok) begin
            n_phase    = rdtc_pkg::PH_IDLE;
            n_fail     = rdtc_pkg::FK_NONE;
            n_attempts = 8'd0;
            n_tag      = '0;
        end
    end

    // result word
    always_comb begin
        o_res_push      = go;
        o_res.accepted  = begin_ok;
        o_res.phase     = n_phase;
        o_res.failure   = n_fail;
        o_res.attempts  = n_attempts;
        o_res.send      = (begin_ok && !begin_zero) || tick_restart;
        o_res.send_tag  = o_res.send ? n_tag : '0;
        o_res.abort     = sending && (((i_cmd.ev == rdtc_pkg::EV_TICK) && (dl_hit || to_hit))
                          || (i_cmd.ev == rdtc_pkg::EV_CANCEL));
        o_res.fin       = begin_zero || tick_dl || cancel_ok ||
                          (res_act && (n_phase != rdtc_pkg::PH_BACKOFF));
        o_res.fin_ok    = o_res.fin && (n_phase == rdtc_pkg::PH_SUCCEEDED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= rdtc_pkg::PH_IDLE;
            r_fail          <= rdtc_pkg::FK_NONE;
            r_attempts      <= '0;
            r_attempt_start <= '0;
            r_deadline_at   <= '0;
            r_backoff_until <= '0;
            r_tag           <= '0;
        end else if (go) begin
            r_phase         <= n_phase;
            r_fail          <= n_fail;
            r_attempts      <= n_attempts;
            r_attempt_start <= n_attempt_start;
            r_deadline_at   <= n_deadline_at;
            r_backoff_until <= n_backoff_until;
            r_tag           <= n_tag;
        end
    end

endmodule

`default_nettype wire

>>> hdl/retry_deadline_transfer_controller_core.sv
// Top level of the retry/deadline transfer controller.
//
// Usage:
//  - Events go in through a queue-style port: a word is taken at a rising edge
//    with push high and full low. Each event carries op, outcome, now_time and tag.
//  - Every event yields exactly one result word, read through empty/pop; the
//    oldest result sits on the o_* ports while empty is low.
//  - Front end decodes the event and forms now+deadline and now+backoff; a
//    two-word command queue separates it from the back end, which holds the
//    transfer state and applies one event per cycle into a two-word result queue.
//  - The command queue registers each event and the result queue each result word.
//  - Throughput: one event per cycle while the result queue has room, set by the
//    state update in the back end; both queues let push and pop run every cycle.
//  - If pop is held low, the result queue fills, the back end stops, the command
//    queue fills and full rises; no word is dropped.
//  - Reset (i_rst_n low, synchronous) empties both queues, returns the transfer
//    to idle and loads the register defaults (3 attempts, 60000/10000/1000 ms).
//  - Configuration writes (i_cfg_we) take effect at once; change them only
//    while no event is in flight.
`default_nettype none

module retry_deadline_transfer_controller_core #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // event port
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_op,
    input  wire logic [1:0]  i_outcome,
    input  wire logic [63:0] i_now_time,
    input  wire logic [31:0] i_transfer_tag,
    // result port
    output logic             empty,
    input  wire logic        pop,
    output logic             o_accepted,
    output logic [2:0]       o_phase_out,
    output logic [2:0]       o_failure_out,
    output logic [7:0]       o_attempt_count,
    output logic             o_send_pulse,
    output logic [31:0]      o_send_tag,
    output logic             o_abort_pulse,
    output logic             o_finished_pulse,
    output logic             o_finished_ok,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    rdtc_pkg::t_cfg    r_cfg;
    rdtc_pkg::t_cmd    cmd_in, cmd_out;
    rdtc_pkg::t_result res_in, res_out;
    logic              cmd_empty, cmd_pop;
    logic              res_full, res_push;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.try_limit       <= rdtc_pkg::RST_TRY_LIMIT;
            r_cfg.total_deadline  <= rdtc_pkg::RST_TOTAL_DEADLINE;
            r_cfg.attempt_timeout <= rdtc_pkg::RST_ATTEMPT_TIMEOUT;
            r_cfg.backoff_time    <= rdtc_pkg::RST_BACKOFF_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rdtc_pkg::CFG_TRY_LIMIT:       r_cfg.try_limit       <= i_cfg_data[7:0];
                rdtc_pkg::CFG_TOTAL_DEADLINE:  r_cfg.total_deadline  <= i_cfg_data;
                rdtc_pkg::CFG_ATTEMPT_TIMEOUT: r_cfg.attempt_timeout <= i_cfg_data;
                rdtc_pkg::CFG_BACKOFF_TIME:    r_cfg.backoff_time    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rdtc_front u_front (
        .i_op             (i_op),
        .i_outcome        (i_outcome),
        .i_now_time       (i_now_time),
        .i_transfer_tag   (i_transfer_tag),
        .i_total_deadline (r_cfg.total_deadline),
        .i_backoff_time   (r_cfg.backoff_time),
        .o_cmd            (cmd_in)
    );

    // command queue between front and back
    rdtc_fifo #(
        .WIDTH ($bits(rdtc_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    rdtc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_try_limit       (r_cfg.try_limit),
        .i_attempt_timeout (r_cfg.attempt_timeout),
        .i_cmd             (cmd_out),
        .i_cmd_valid       (!cmd_empty),
        .o_cmd_pop         (cmd_pop),
        .i_res_full        (res_full),
        .o_res             (res_in),
        .o_res_push        (res_push)
    );

    // result queue toward the consumer
    rdtc_fifo #(
        .WIDTH ($bits(rdtc_pkg::t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_accepted       = res_out.accepted;
    assign o_phase_out      = res_out.phase;
    assign o_failure_out    = res_out.failure;
    assign o_attempt_count  = res_out.attempts;
    assign o_send_pulse     = res_out.send;
    assign o_send_tag       = res_out.send_tag;
    assign o_abort_pulse    = res_out.abort;
    assign o_finished_pulse = res_out.fin;
    assign o_finished_ok    = res_out.fin_ok;

endmodule

`default_nettype wire

>>> hdl/rdtc_checker.sv
// Port-level checks of the transfer controller, bound to the top level.
`default_nettype none

module rdtc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  o_phase_out,
    input wire logic [2:0]  o_failure_out,
    input wire logic        o_send_pulse,
    input wire logic [31:0] o_send_tag,
    input wire logic        o_finished_pulse,
    input wire logic        o_finished_ok
);

    // a success report always comes with the completion flag
    a_ok_needs_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_finished_ok) |-> o_finished_pulse)
        else $error("finished_ok without finished_pulse");

    a_tag_only_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_send_pulse) |-> (o_send_tag == 32'd0))
        else $error("send_tag nonzero without send");

    // an active transfer carries no failure kind
    a_busy_no_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_phase_out == rdtc_pkg::PH_SENDING ||
                    o_phase_out == rdtc_pkg::PH_BACKOFF))
        |-> (o_failure_out == rdtc_pkg::FK_NONE))
        else $error("failure kind set while busy");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_phase_out)))
        else $error("stalled result changed");

endmodule

bind retry_deadline_transfer_controller_core rdtc_checker u_rdtc_checker (.*);

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the retry/deadline transfer controller core.
`timescale 1ns / 100ps

module tb;

    // Codes the package leaves unnamed
    localparam logic [1:0] OUTC_RETRY     = 2'd1;
    localparam logic [1:0] OUTC_RETRY_ALT = 2'd3;   // undefined outcome, acts as retryable
    localparam logic [2:0] OPC_SPARE_A    = 3'd5;   // op codes 5..7 do nothing
    localparam logic [2:0] OPC_SPARE_C    = 3'd7;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 13;
    localparam int PHASE_EVENTS = 145;

    // One event word as pushed into the block
    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  oc;
        logic [63:0] now;
        logic [31:0] tag;
    } t_ev_word;

    // ---------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        push           = 1'b0;
    logic        full;
    logic [2:0]  i_op           = '0;
    logic [1:0]  i_outcome      = '0;
    logic [63:0] i_now_time     = '0;
    logic [31:0] i_transfer_tag = '0;
    logic        empty;
    logic        pop            = 1'b0;
    logic        o_accepted;
    logic [2:0]  o_phase_out;
    logic [2:0]  o_failure_out;
    logic [7:0]  o_attempt_count;
    logic        o_send_pulse;
    logic [31:0] o_send_tag;
    logic        o_abort_pulse;
    logic        o_finished_pulse;
    logic        o_finished_ok;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_idx      = '0;
    logic [31:0] i_cfg_data     = '0;

    retry_deadline_transfer_controller_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_outcome        (i_outcome),
        .i_now_time       (i_now_time),
        .i_transfer_tag   (i_transfer_tag),
        .empty            (empty),
        .pop              (pop),
        .o_accepted       (o_accepted),
        .o_phase_out      (o_phase_out),
        .o_failure_out    (o_failure_out),
        .o_attempt_count  (o_attempt_count),
        .o_send_pulse     (o_send_pulse),
        .o_send_tag       (o_send_tag),
        .o_abort_pulse    (o_abort_pulse),
        .o_finished_pulse (o_finished_pulse),
        .o_finished_ok    (o_finished_ok),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Transfer predictor: private copy of registers and transfer state
    // ---------------------------------------------------------------
    logic [7:0]  cfg_max     = rdtc_pkg::RST_TRY_LIMIT;
    logic [31:0] cfg_budget  = rdtc_pkg::RST_TOTAL_DEADLINE;
    logic [31:0] cfg_timeout = rdtc_pkg::RST_ATTEMPT_TIMEOUT;
    logic [31:0] cfg_backoff = rdtc_pkg::RST_BACKOFF_TIME;

    rdtc_pkg::t_phase tr_phase    = rdtc_pkg::PH_IDLE;
    rdtc_pkg::t_fail  tr_fail     = rdtc_pkg::FK_NONE;
    logic [7:0]       tr_tries    = '0;
    logic [63:0]      tr_start    = '0;
    logic [63:0]      tr_deadline = '0;
    logic [63:0]      tr_wait_end = '0;
    logic [31:0]      tr_tag      = '0;
    bit               fl_send, fl_abort, fl_fin;   // pulses of the current event

    function automatic bit xfer_busy();
        return tr_phase == rdtc_pkg::PH_SENDING || tr_phase == rdtc_pkg::PH_BACKOFF;
    endfunction

    task automatic close_transfer(input rdtc_pkg::t_phase p, input rdtc_pkg::t_fail f);
        tr_phase = p;
        tr_fail  = f;
        fl_fin   = 1'b1;
    endtask

    task automatic launch_attempt(input logic [63:0] now);
        tr_tries = tr_tries + 8'd1;   // wraps at 8 bits
        tr_start = now;
        tr_phase = rdtc_pkg::PH_SENDING;
        fl_send  = 1'b1;
    endtask

    // Attempt outcome; only meaningful while an attempt is in flight
    task automatic take_outcome(input logic [1:0] oc, input logic [63:0] now);
        if (tr_phase == rdtc_pkg::PH_SENDING) begin
            if (oc == rdtc_pkg::OUTC_SUCCESS)
                close_transfer(rdtc_pkg::PH_SUCCEEDED, rdtc_pkg::FK_NONE);
            else if (oc == rdtc_pkg::OUTC_PERMANENT)
                close_transfer(rdtc_pkg::PH_FAILED, rdtc_pkg::FK_PERMANENT);
            else if (tr_tries >= cfg_max)
                close_transfer(rdtc_pkg::PH_FAILED, rdtc_pkg::FK_EXHAUSTED);
            else if (now >= tr_deadline)
                close_transfer(rdtc_pkg::PH_FAILED, rdtc_pkg::FK_DEADLINE);
            else begin
                tr_phase    = rdtc_pkg::PH_BACKOFF;
                tr_wait_end = now + 64'(cfg_backoff);
            end
        end
    endtask

    task automatic advance_transfer(input t_ev_word w, output rdtc_pkg::t_result r);
        logic acc;
        acc      = 1'b0;
        fl_send  = 1'b0;
        fl_abort = 1'b0;
        fl_fin   = 1'b0;
        case (w.op)
            rdtc_pkg::OPC_BEGIN: begin
                if (!xfer_busy()) begin
                    acc         = 1'b1;
                    tr_tag      = w.tag;
                    tr_tries    = '0;
                    tr_fail     = rdtc_pkg::FK_NONE;
                    tr_wait_end = '0;
                    tr_deadline = w.now + 64'(cfg_budget);
                    if (cfg_max == '0)
                        close_transfer(rdtc_pkg::PH_FAILED, rdtc_pkg::FK_EXHAUSTED);
                    else
                        launch_attempt(w.now);
                end
            end
            rdtc_pkg::OPC_RESULT: take_outcome(w.oc, w.now);
            rdtc_pkg::OPC_TICK: begin
                if (xfer_busy()) begin
                    // overall deadline wins over everything else
                    if (w.now >= tr_deadline) begin
                        if (tr_phase == rdtc_pkg::PH_SENDING)
                            fl_abort = 1'b1;
                        close_transfer(rdtc_pkg::PH_FAILED, rdtc_pkg::FK_DEADLINE);
                    end else if (tr_phase == rdtc_pkg::PH_SENDING) begin
                        if (w.now - tr_start >= 64'(cfg_timeout)) begin
                            fl_abort = 1'b1;
                            take_outcome(OUTC_RETRY, w.now);
                        end
                    end else if (w.now >= tr_wait_end) begin
                        launch_attempt(w.now);
                    end
                end
            end
            rdtc_pkg::OPC_CANCEL: begin
                if (xfer_busy()) begin
                    if (tr_phase == rdtc_pkg::PH_SENDING)
                        fl_abort = 1'b1;
                    close_transfer(rdtc_pkg::PH_CANCELLED, rdtc_pkg::FK_CANCELLED);
                end
            end
            rdtc_pkg::OPC_RELEASE: begin
                if (!xfer_busy()) begin
                    tr_phase = rdtc_pkg::PH_IDLE;
                    tr_fail  = rdtc_pkg::FK_NONE;
                    tr_tries = '0;
                    tr_tag   = '0;
                end
            end
            default: ;
        endcase
        r.accepted = acc;
        r.phase    = tr_phase;
        r.failure  = tr_fail;
        r.attempts = tr_tries;
        r.send     = fl_send;
        r.send_tag = fl_send ? tr_tag : '0;
        r.abort    = fl_abort;
        r.fin      = fl_fin;
        r.fin_ok   = fl_fin && tr_phase == rdtc_pkg::PH_SUCCEEDED;
    endtask

    // ---------------------------------------------------------------
    // Queues shared by stimulus, driver and monitor
    // ---------------------------------------------------------------
    t_ev_word          pending[$];      // words not yet taken by the block
    rdtc_pkg::t_result status_due[$];   // predicted status words, oldest first
    int                mismatches = 0;

    // ---------------------------------------------------------------
    // Event driver: bursts of random length, random gaps in between
    // ---------------------------------------------------------------
    bit                took;
    int                burst_left = 8;
    int                gap_left   = 0;
    t_ev_word          taken_word;
    rdtc_pkg::t_result predicted;

    always @(posedge i_clk) begin
        took = push && !full;
        if (took) begin
            taken_word = pending.pop_front();
            advance_transfer(taken_word, predicted);
            status_due.push_back(predicted);
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                // one burst in four runs straight into the next
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    always @(negedge i_clk) begin
        if (push && !took) begin
            // word still offered, keep it on the bus
        end else if (gap_left > 0) begin
            push <= 1'b0;
            gap_left--;
        end else if (pending.size() > 0) begin
            push           <= 1'b1;
            i_op           <= pending[0].op;
            i_outcome      <= pending[0].oc;
            i_now_time     <= pending[0].now;
            i_transfer_tag <= pending[0].tag;
        end else begin
            push <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Result side: pop follows a random 32-bit pattern, redrawn each lap.
    // Bit 0 always set so the reader never stalls forever.
    // ---------------------------------------------------------------
    logic [31:0] pop_pattern = '1;
    logic [4:0]  pop_pos     = '0;

    always @(negedge i_clk) begin
        if (pop_pos == '0) begin
            case ($urandom_range(0, 3))
                0:       pop_pattern = '1;           // no stalls
                1:       pop_pattern = 32'h0000_0001; // long stall
                default: pop_pattern = $urandom | 32'h1;
            endcase
        end
        pop <= pop_pattern[pop_pos];
        pop_pos = pop_pos + 5'd1;
    end

    function automatic string show(input rdtc_pkg::t_result s);
        return $sformatf("acc=%0d ph=%0d fk=%0d cnt=%0d snd=%0d tag=%h abt=%0d fin=%0d ok=%0d",
                         s.accepted, s.phase, s.failure, s.attempts, s.send,
                         s.send_tag, s.abort, s.fin, s.fin_ok);
    endfunction

    // Monitor: compare each popped word against the oldest prediction
    rdtc_pkg::t_result seen, wanted;

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen.accepted = o_accepted;
            seen.phase    = rdtc_pkg::t_phase'(o_phase_out);
            seen.failure  = rdtc_pkg::t_fail'(o_failure_out);
            seen.attempts = o_attempt_count;
            seen.send     = o_send_pulse;
            seen.send_tag = o_send_tag;
            seen.abort    = o_abort_pulse;
            seen.fin      = o_finished_pulse;
            seen.fin_ok   = o_finished_ok;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %s", show(seen));
            end else begin
                wanted = status_due.pop_front();
                if (seen.accepted !== wanted.accepted || seen.phase !== wanted.phase ||
                    seen.failure !== wanted.failure || seen.attempts !== wanted.attempts ||
                    seen.send !== wanted.send || seen.send_tag !== wanted.send_tag ||
                    seen.abort !== wanted.abort || seen.fin !== wanted.fin ||
                    seen.fin_ok !== wanted.fin_ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t\n  exp %s\n  got %s",
                                 $realtime, show(wanted), show(seen));
                end
            end
        end
    end

    // Watchdog
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    logic [63:0] clock_ms = '0;   // running time stamp of generated events

    task automatic queue_event(input logic [2:0] op, input logic [1:0] oc,
                               input logic [63:0] now, input logic [31:0] tag);
        t_ev_word w;
        w.op  = op;
        w.oc  = oc;
        w.now = now;
        w.tag = tag;
        pending.push_back(w);
    endtask

    // Register write sequence; the model follows at the edge that takes each write
    task automatic load_registers(input logic [7:0] m, input logic [31:0] budget,
                                  input logic [31:0] tmo, input logic [31:0] boff);
        logic [1:0]  idx_list[4];
        logic [31:0] val_list[4];
        idx_list = '{rdtc_pkg::CFG_TRY_LIMIT, rdtc_pkg::CFG_TOTAL_DEADLINE,
                     rdtc_pkg::CFG_ATTEMPT_TIMEOUT, rdtc_pkg::CFG_BACKOFF_TIME};
        val_list = '{32'(m), budget, tmo, boff};
        for (int k = 0; k < 4; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= val_list[k];
            @(posedge i_clk);
            case (idx_list[k])
                rdtc_pkg::CFG_TRY_LIMIT:       cfg_max     = val_list[k][7:0];
                rdtc_pkg::CFG_TOTAL_DEADLINE:  cfg_budget  = val_list[k];
                rdtc_pkg::CFG_ATTEMPT_TIMEOUT: cfg_timeout = val_list[k];
                rdtc_pkg::CFG_BACKOFF_TIME:    cfg_backoff = val_list[k];
                default: ;
            endcase
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender holds off until every predicted word has been read back.
    task automatic wait_quiet();
        @(posedge i_clk);
        while (pending.size() != 0 || status_due.size() != 0 || push)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom_range(1, 20);
            2, 3:    return $urandom_range(20, 5000);
            4:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Time step between events, aimed around the configured durations
    function automatic logic [63:0] pick_step();
        logic [63:0] jitter;
        jitter = 64'($urandom_range(0, 2)) - 64'd1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return 64'($urandom_range(1, 50));
            3:       return 64'(cfg_backoff) + jitter;
            4, 5:    return 64'(cfg_timeout) + jitter;
            6:       return 64'(cfg_budget) + jitter;
            7:       return 64'($urandom_range(1, 3000));
            8:       return 64'($urandom);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [1:0] pick_outcome();
        case ($urandom_range(0, 9))
            0, 1:    return rdtc_pkg::OUTC_SUCCESS;
            2:       return rdtc_pkg::OUTC_PERMANENT;
            3:       return OUTC_RETRY_ALT;
            default: return OUTC_RETRY;
        endcase
    endfunction

    // Mostly well-formed transfers with random timing, plus some noise words
    task automatic queue_phase(input int count);
        int n, steps, r;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 12) begin
                queue_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                            {$urandom, $urandom}, $urandom);
                n++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    clock_ms = {$urandom, $urandom};
                else if (r < 12)
                    clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 100000));
                queue_event(rdtc_pkg::OPC_BEGIN, 2'($urandom_range(0, 3)), clock_ms,
                            $urandom);
                n++;
                steps = $urandom_range(1, 10);
                for (int s = 0; s < steps; s++) begin
                    clock_ms = clock_ms + pick_step();
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        queue_event(rdtc_pkg::OPC_RESULT, pick_outcome(), clock_ms,
                                    $urandom);
                    else if (r < 85)
                        queue_event(rdtc_pkg::OPC_TICK, 2'($urandom_range(0, 3)),
                                    clock_ms, $urandom);
                    else if (r < 90)
                        queue_event(rdtc_pkg::OPC_CANCEL, 2'($urandom_range(0, 3)),
                                    clock_ms, $urandom);
                    else if (r < 95)
                        queue_event(rdtc_pkg::OPC_BEGIN, 2'($urandom_range(0, 3)),
                                    clock_ms, $urandom);
                    else
                        queue_event(rdtc_pkg::OPC_RELEASE, 2'($urandom_range(0, 3)),
                                    clock_ms, $urandom);
                    n++;
                end
                if ($urandom_range(0, 99) < 85) begin
                    queue_event(rdtc_pkg::OPC_RELEASE, rdtc_pkg::OUTC_SUCCESS, clock_ms,
                                $urandom);
                    n++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part, reset registers (3 tries, 60000/10000/1000 ms)
        // release, tick and result while idle
        queue_event(rdtc_pkg::OPC_RELEASE, rdtc_pkg::OUTC_SUCCESS, 64'd100, '0);
        queue_event(rdtc_pkg::OPC_TICK,    rdtc_pkg::OUTC_SUCCESS, 64'd100, '0);
        queue_event(rdtc_pkg::OPC_RESULT,  rdtc_pkg::OUTC_SUCCESS, 64'd100, '0);
        queue_event(rdtc_pkg::OPC_BEGIN,   rdtc_pkg::OUTC_SUCCESS, 64'd1000, '1);
        // begin while busy
        queue_event(rdtc_pkg::OPC_BEGIN,   rdtc_pkg::OUTC_SUCCESS, 64'd1001, 32'h1234_5678);
        queue_event(rdtc_pkg::OPC_RESULT,  OUTC_RETRY, 64'd1100, '0);   // into backoff
        // result while not sending, release while busy
        queue_event(rdtc_pkg::OPC_RESULT,  rdtc_pkg::OUTC_SUCCESS, 64'd1200, '0);
        queue_event(rdtc_pkg::OPC_RELEASE, rdtc_pkg::OUTC_SUCCESS, 64'd1300, '0);
        // backoff over, attempt timeout, third attempt
        queue_event(rdtc_pkg::OPC_TICK,    rdtc_pkg::OUTC_SUCCESS, 64'd2100, '0);
        queue_event(rdtc_pkg::OPC_TICK,    rdtc_pkg::OUTC_SUCCESS, 64'd12100, '0);
        queue_event(rdtc_pkg::OPC_TICK,    rdtc_pkg::OUTC_SUCCESS, 64'd13100, '0);
        queue_event(rdtc_pkg::OPC_RESULT,  OUTC_RETRY_ALT, 64'd13200, '0);  // exhausted
        queue_event(rdtc_pkg::OPC_RELEASE, rdtc_pkg::OUTC_SUCCESS, 64'd13300, '0);
        queue_event(rdtc_pkg::OPC_BEGIN,   rdtc_pkg::OUTC_SUCCESS, 64'd20000, '0);
        queue_event(rdtc_pkg::OPC_RESULT,  rdtc_pkg::OUTC_PERMANENT, 64'd20010, '0);
        // begin from terminal, then cancel while sending
        queue_event(rdtc_pkg::OPC_BEGIN,   rdtc_pkg::OUTC_SUCCESS, 64'd30000, 32'hA5A5_5A5A);
        queue_event(rdtc_pkg::OPC_CANCEL,  rdtc_pkg::OUTC_SUCCESS, 64'd30001, '0);
        queue_event(rdtc_pkg::OPC_BEGIN,   rdtc_pkg::OUTC_SUCCESS, 64'd40000, 32'h0F0F_F0F0);
        queue_event(rdtc_pkg::OPC_RESULT,  OUTC_RETRY, 64'd40010, '0);
        // cancel in backoff
        queue_event(rdtc_pkg::OPC_CANCEL,  rdtc_pkg::OUTC_SUCCESS, 64'd40020, '0);
        // deadline sum wraps past 2^64, next tick is already late
        queue_event(rdtc_pkg::OPC_BEGIN,   rdtc_pkg::OUTC_SUCCESS,
                    64'hFFFF_FFFF_FFFF_FFF6, $urandom);
        queue_event(rdtc_pkg::OPC_TICK,    OUTC_RETRY_ALT, 64'hFFFF_FFFF_FFFF_FFFF, '1);
        queue_event(OPC_SPARE_A, OUTC_RETRY_ALT, '1, '1);
        queue_event(OPC_SPARE_C, rdtc_pkg::OUTC_PERMANENT, {$urandom, $urandom}, $urandom);
        queue_event(rdtc_pkg::OPC_BEGIN,   rdtc_pkg::OUTC_SUCCESS, 64'd50, $urandom);
        queue_event(rdtc_pkg::OPC_RESULT,  rdtc_pkg::OUTC_SUCCESS, 64'd60, '0);  // success
        // leave a transfer in backoff so the next phase lowers the try limit under it
        queue_event(rdtc_pkg::OPC_BEGIN,   rdtc_pkg::OUTC_SUCCESS, 64'd70, $urandom);
        queue_event(rdtc_pkg::OPC_RESULT,  OUTC_RETRY, 64'd80, '0);
        wait_quiet();

        // Random phases; register extremes first, then random settings
        clock_ms = 64'd100;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       load_registers('0, pick_duration(), pick_duration(),
                                        pick_duration());
                1:       load_registers('1, '1, '1, '1);
                2:       load_registers(8'd1, '0, '0, '0);
                default: load_registers(($urandom_range(0, 4) == 0) ? 8'($urandom) :
                                        8'($urandom_range(1, 4)),
                                        pick_duration(), pick_duration(), pick_duration());
            endcase
            queue_phase(PHASE_EVENTS);
            wait_quiet();
        end

        repeat (6) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
